// ===== sv/smt_pkg.sv =====
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the softmax block
// Holds widths, the exponential bit table and the front-to-back command type.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned IdxW     = $clog2(MaxLen);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned SumW     = 22;
  localparam logic [15:0] InvTempOne = 16'd256;

  // Command handed from the front part to the back part at the end of a vector.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [15:0]     max_score;
    logic            dropped;
  } smt_cmd_t;

  // K[b] = round(65536 * exp(-2^b / 256)).
  function automatic logic [15:0] exp_k(input logic [3:0] b);
    logic [15:0] k;
    begin
      case (b)
        4'd0:    k = 16'd65280;
        4'd1:    k = 16'd65026;
        4'd2:    k = 16'd64520;
        4'd3:    k = 16'd63520;
        4'd4:    k = 16'd61565;
        4'd5:    k = 16'd57835;
        4'd6:    k = 16'd51039;
        4'd7:    k = 16'd39750;
        4'd8:    k = 16'd24109;
        4'd9:    k = 16'd8869;
        4'd10:   k = 16'd1200;
        4'd11:   k = 16'd22;
        default: k = 16'd0;
      endcase
      return k;
    end
  endfunction

endpackage

// ===== sv/softmax_with_temperature_top.sv =====
// ----------------------------------------------------------------------------
// softmax_with_temperature_top: streaming softmax with temperature
// Front intake plus back exponential/normalize engine.
// ----------------------------------------------------------------------------
// Scores stream in one per transaction (signed Q8.8, tlast marks the end of
// a vector) and are accepted one per cycle while the intake stores them. When
// the last score lands, the back engine computes exp((x - max) * inv_temp)
// for each stored score with a shared multiplier that steps through the 12
// bits of the scaled distance and accumulates the terms into a sum, then
// divides each term by the sum with a one-bit-per-cycle divider and
// streams unsigned Q1.15 probabilities out, tlast on the final one and
// tuser set when scores past the 64-entry capacity were dropped.
// While the back engine works on a vector, new scores are held off. The
// inv_temperature register (Q8.8, zero means 1.0) is sampled when a vector
// starts processing and should be written only while the block is idle.
module softmax_with_temperature_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] score
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] probability
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] overflowed
);
  import smt_pkg::*;

  logic [15:0]     inv_temp_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [15:0]     wr_data;
  logic            cmd_valid, cmd_ready;
  smt_cmd_t        cmd;

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_temp_q <= InvTempOne;
    end else if (cfg_valid_i) begin
      inv_temp_q <= cfg_data_i;
    end
  end

  smt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .score_i    (s_axis_tdata),
    .is_last_i  (s_axis_tlast),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  smt_back u_back (
    .clk_i, .rst_ni,
    .inv_temp_i   (inv_temp_q),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .probability_o(m_axis_tdata),
    .final_flag_o (m_axis_tlast),
    .overflowed_o (m_axis_tuser)
  );

endmodule

// ===== sv/smt_front.sv =====
// ----------------------------------------------------------------------------
// smt_front: score intake
// Stores scores, tracks the running maximum and the drop flag, and issues
// one command per vector toward the back part.
// ----------------------------------------------------------------------------
module smt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         score_i,
  input  logic                is_last_i,
  output logic                wr_en_o,
  output logic [smt_pkg::IdxW-1:0] wr_addr_o,
  output logic [15:0]         wr_data_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output smt_pkg::smt_cmd_t   cmd_o
);
  import smt_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     max_q, max_d;
  logic            drop_q, drop_d;
  logic            fire, room;

  // A vector may be loaded only while the back part is free to take its command.
  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CntW'(MaxLen));

  assign wr_en_o   = fire && room;
  assign wr_addr_o = cnt_q[IdxW-1:0];
  assign wr_data_o = score_i;

  always_comb begin
    cnt_d  = cnt_q;
    max_d  = max_q;
    drop_d = drop_q;
    if (fire) begin
      if (room) begin
        cnt_d = cnt_q + 1'b1;
        if ($signed(score_i) > $signed(max_q)) max_d = score_i;
      end else begin
        drop_d = 1'b1;
      end
    end
    cmd_o.count     = cnt_d;
    cmd_o.max_score = max_d;
    cmd_o.dropped   = drop_d;
    if (fire && is_last_i) begin
      cnt_d  = '0;
      max_d  = 16'h8000;
      drop_d = 1'b0;
    end
  end

  assign cmd_valid_o = fire && is_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      max_q  <= 16'h8000;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      max_q  <= max_d;
      drop_q <= drop_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxLen))
    else $error("element count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_last_i) |=> (cnt_q == '0 && !drop_q))
    else $error("vector state not cleared after last score");
  assert property (@(posedge clk_i) disable iff (!rst_ni) drop_q |-> cnt_q == CntW'(MaxLen))
    else $error("drop flag set below capacity");

endmodule

// ===== sv/smt_back.sv =====
// ----------------------------------------------------------------------------
// smt_back: exponential and normalize passes
// Runs a shared exponential unit over the stored vector, accumulates the sum,
// then divides each term by the sum with a restoring divider.
// ----------------------------------------------------------------------------
module smt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         inv_temp_i,
  input  logic                wr_en_i,
  input  logic [smt_pkg::IdxW-1:0] wr_addr_i,
  input  logic [15:0]         wr_data_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  smt_pkg::smt_cmd_t   cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         probability_o,
  output logic                final_flag_o,
  output logic                overflowed_o
);
  import smt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StExp  = 3'd2;
  localparam logic [2:0] StNRd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [15:0] score_mem [MaxLen];
  logic [15:0] exp_mem   [MaxLen];
  logic [15:0] score_rd_q, exp_rd_q;
  logic [IdxW-1:0] rd_addr;

  logic [2:0]      st_q;
  smt_cmd_t        cmd_q;
  logic [15:0]     inv_q;
  logic [CntW-1:0] idx_q;
  logic [SumW-1:0] sum_q;
  logic [3:0]      bit_q;
  logic [11:0]     m_q;
  logic [16:0]     acc_q;
  logic [31:0]     prod_q;
  logic            phase_q;
  logic [36:0]     num_q;
  logic [SumW:0]   rem_q;
  logic [5:0]      dstep_q;
  logic [15:0]     prob_q;
  logic            fin_q, ovf_q, oval_q;

  logic [16:0] diff;
  logic [33:0] dprod;
  logic [SumW:0] rem_sh;
  logic [15:0] e_val;

  assign rd_addr = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) score_mem[wr_addr_i] <= wr_data_i;
    score_rd_q <= score_mem[rd_addr];
    exp_rd_q   <= exp_mem[rd_addr];
    if (st_q == StExp && bit_q == 4'd12 && !phase_q) exp_mem[rd_addr] <= e_val;
  end

  assign cmd_ready_o = (st_q == StIdle);
  assign diff  = {cmd_q.max_score[15], cmd_q.max_score} - {score_rd_q[15], score_rd_q};
  assign dprod = 34'(diff) * 34'(inv_q);
  assign e_val = 16'((acc_q + 17'd1) >> 1);
  assign rem_sh = {rem_q[SumW-1:0], num_q[36]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      oval_q  <= 1'b0;
      idx_q   <= '0;
      bit_q   <= '0;
      phase_q <= 1'b0;
      dstep_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            inv_q <= (inv_temp_i == '0) ? InvTempOne : inv_temp_i;
            idx_q <= '0;
            sum_q <= '0;
            st_q  <= (cmd_i.count == '0) ? StIdle : StRead;
          end
        end
        StRead: begin
          // Memory read is registered; wait for the read data, then load m.
          if (phase_q) begin
            phase_q <= 1'b0;
            if (dprod[33:8] >= 26'd4096) begin
              acc_q <= '0;
              m_q   <= '0;
            end else begin
              acc_q <= 17'h10000;
              m_q   <= dprod[19:8];
            end
            bit_q <= '0;
            st_q  <= StExp;
          end else begin
            phase_q <= 1'b1;
          end
        end
        StExp: begin
          if (bit_q == 4'd12) begin
            sum_q <= sum_q + SumW'(e_val);
            if (idx_q + 1'b1 == cmd_q.count) begin
              idx_q <= '0;
              st_q  <= StNRd;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= StRead;
            end
          end else if (!phase_q) begin
            prod_q  <= 32'(acc_q) * 32'(exp_k(bit_q));
            phase_q <= m_q[bit_q];
            if (!m_q[bit_q]) bit_q <= bit_q + 1'b1;
          end else begin
            acc_q   <= 17'((prod_q + 32'd32768) >> 16);
            phase_q <= 1'b0;
            bit_q   <= bit_q + 1'b1;
          end
        end
        StNRd: begin
          if (phase_q) begin
            phase_q <= 1'b0;
            num_q   <= {6'd0, exp_rd_q, 15'd0} + 37'(sum_q >> 1);
            rem_q   <= '0;
            dstep_q <= '0;
            st_q    <= StDiv;
          end else begin
            phase_q <= 1'b1;
          end
        end
        StDiv: begin
          // One quotient bit per cycle over a 37-bit dividend.
          if (rem_sh >= {1'b0, sum_q}) begin
            rem_q <= rem_sh - {1'b0, sum_q};
            num_q <= {num_q[35:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            num_q <= {num_q[35:0], 1'b0};
          end
          dstep_q <= dstep_q + 1'b1;
          if (dstep_q == 6'd36) st_q <= StOut;
        end
        StOut: begin
          if (!oval_q || out_ready_i) begin
            oval_q <= 1'b1;
            prob_q <= num_q[15:0];
            fin_q  <= (idx_q + 1'b1 == cmd_q.count);
            ovf_q  <= cmd_q.dropped;
            if (idx_q + 1'b1 == cmd_q.count) begin
              st_q <= StIdle;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= StNRd;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
      if (oval_q && out_ready_i && !(st_q == StOut)) oval_q <= 1'b0;
    end
  end

  assign out_valid_o   = oval_q;
  assign probability_o = prob_q;
  assign final_flag_o  = fin_q;
  assign overflowed_o  = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> (idx_q < cmd_q.count))
    else $error("back index past vector length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !out_ready_i) |=> oval_q)
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> (sum_q != '0))
    else $error("normalize with zero sum");

endmodule
